@@ rtl/core/octab_pkg.sv @@
// shared types, constants and bound function for the octave abundance histogram
`timescale 1ns / 1ps

package octab_pkg;

   // fixed field widths
   localparam int VAL_W        = 32;
   localparam int IDX_W        = 5;
   localparam int CNT_W        = 33;
   localparam int MAX_BINS     = 31;
   localparam int NUM_BINS_DEF = 16;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [0:0] REG_BIN_METHOD = 1'b0;

   // binning methods
   typedef enum logic [1:0] {
      BM_POW2_MINUS1 = 2'd0,
      BM_POW2        = 2'd1,
      BM_ROOT2       = 2'd2,
      BM_HALF_CREDIT = 2'd3
   } bin_method_type;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIN,
      ST_READ,
      ST_MODIFY,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   // classifier result handed to the sequencer
   typedef struct packed {
      logic [IDX_W-1:0] bin;
      logic             half;
   } bin_res_type;

   // floor(2^(b+1)/sqrt2)
   localparam logic [VAL_W-1:0] ROOT2_BOUNDS [0:MAX_BINS-1] = '{
      32'd1, 32'd2, 32'd5, 32'd11, 32'd22, 32'd45, 32'd90, 32'd181, 32'd362, 32'd724,
      32'd1448, 32'd2896, 32'd5792, 32'd11585, 32'd23170, 32'd46340, 32'd92681,
      32'd185363, 32'd370727, 32'd741455, 32'd1482910, 32'd2965820, 32'd5931641,
      32'd11863283, 32'd23726566, 32'd47453132, 32'd94906265, 32'd189812531,
      32'd379625062, 32'd759250124, 32'd1518500249
   };

   // upper bound of octave bin b under method m
   function automatic logic [VAL_W-1:0] bound_of(bin_method_type m, logic [IDX_W-1:0] b);
      logic [IDX_W-1:0] bc;
      logic [VAL_W:0]   p1;
      logic [VAL_W:0]   p0;
      logic [VAL_W-1:0] res;
      bc = (b > IDX_W'(MAX_BINS - 1)) ? IDX_W'(MAX_BINS - 1) : b;
      p1 = (VAL_W+1)'(1) << (bc + IDX_W'(1));
      p0 = (VAL_W+1)'(1) << bc;
      unique case (m)
         BM_POW2_MINUS1: res = VAL_W'(p1 - (VAL_W+1)'(1));
         BM_POW2:        res = VAL_W'(p1);
         BM_ROOT2:       res = ROOT2_BOUNDS[bc];
         BM_HALF_CREDIT: res = VAL_W'(p0);
         default:        res = VAL_W'(p0);
      endcase
      return res;
   endfunction

endpackage

@@ rtl/core/octab_binner.sv @@
// octave bin classifier: parallel bound compares, priority pick, registered result
`timescale 1ns / 1ps

module octab_binner
   import octab_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic             clock,
   input  logic             load,
   input  logic [VAL_W-1:0] value,
   input  bin_method_type   method,
   output bin_res_type      bin_res
);

   bin_res_type res_ff;
   bin_res_type res_in;

   // lowest bin whose bound covers the value, last bin otherwise
   always_comb begin
      logic [VAL_W-1:0] bnd;
      logic             hit;
      logic             eq_sel;
      res_in.bin = IDX_W'(NUM_BINS - 1);
      hit        = 1'b0;
      eq_sel     = 1'b0;
      for (int b = NUM_BINS - 2; b >= 0; b--) begin
         bnd = bound_of(method, IDX_W'(b));
         if (value <= bnd) begin
            res_in.bin = IDX_W'(b);
            eq_sel     = (value == bnd);
            hit        = 1'b1;
         end
      end
      // boundary hit splits the credit, except at the last bin
      res_in.half = (method == BM_HALF_CREDIT) && hit && eq_sel;
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign bin_res = res_ff;

endmodule

@@ rtl/core/octab_count_ram.sv @@
// bin count memory: registered synchronous read, one write port, per-entry valid bits
`timescale 1ns / 1ps

module octab_count_ram
   import octab_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int AW      = $clog2(NUM_BINS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic             rd_clr,
   input  logic [AW-1:0]    rd_addr,
   output logic [CNT_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CNT_W-1:0] wr_data
);

   logic [CNT_W-1:0]    mem [NUM_BINS];
   logic [CNT_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;
   logic [NUM_BINS-1:0] valid_ff;
   logic [NUM_BINS-1:0] valid_in;

   // memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits: set on write, dropped on a clearing read
   always_comb begin
      valid_in = valid_ff;
      if (rd_en && rd_clr) begin
         valid_in[rd_addr] = 1'b0;
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // entry never written since reset or last emit reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/core/octave_abundance_histogram.sv @@
// octave abundance histogram top level: csr, sequencer, emit path and output register
//
//  channel  | direction | transfer fields
//  ---------+-----------+--------------------------------------------------------------
//  req_*    | in        | tdata: abundance[31:0]; tlast: end_of_set
//  rsp_*    | out       | tdata: bin_index, otus_in_bin, total_otus, modal_bin; tlast: is_last
//  csr_*    | in/out    | bin_method at byte address 0
//
//  an input item is classified first; unless its abundance is zero, the count memory is then
//  read and written back per bin touched, one bin for a whole count and two for a split one
//  an end_of_set item then emits NUM_BINS results, one count memory read per bin, a read
//  waiting for the prior result to be taken; req_tready is low until the last result is taken
//  reset clears state, valid bits and bin_method; no clearing pass is needed
//  rsp holds its payload while rsp_tready is low
`timescale 1ns / 1ps

module octave_abundance_histogram
   import octab_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,    // [31:0] abundance
   input  logic              req_tlast,
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [79:0]       rsp_tdata,    // [4:0] bin_index, [36:5] otus_in_bin,
                                           // [68:37] total_otus, [73:69] modal_bin, rest 0
   output logic              rsp_tlast,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW = $clog2(NUM_BINS);
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);

   state_type        state_ff, state_in;
   bin_method_type   method_ff;
   logic [VAL_W-1:0] value_ff;
   logic             eos_ff;
   logic             pass2_ff;
   logic [AW-1:0]    emit_idx_ff;
   logic [VAL_W-1:0] total_ff, total_in;
   logic [VAL_W-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0] best_bin_ff, best_bin_in;

   logic [IDX_W-1:0] out_bin_ff;
   logic [VAL_W-1:0] out_cnt_ff;
   logic             out_last_ff;
   logic [VAL_W-1:0] out_total_ff;
   logic [IDX_W-1:0] out_modal_ff;
   logic             out_valid_ff;

   bin_res_type      bin_res;
   logic             bin_load;
   logic             mem_rd, mem_clr, mem_wr;
   logic [AW-1:0]    mem_rd_addr, upd_addr;
   logic [CNT_W-1:0] mem_rd_data, mem_wr_data;
   logic [CNT_W:0]   upd_sum;
   logic [VAL_W-1:0] emit_cnt;
   logic [VAL_W:0]   total_sum;
   logic             out_load;
   logic             req_xfer, rsp_xfer, csr_wr;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = out_valid_ff && rsp_tready;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= BM_POW2_MINUS1;
      end else if (csr_wr && (csr_paddr[2] == REG_BIN_METHOD)) begin
         method_ff <= bin_method_type'(csr_pwdata[1:0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_BIN_METHOD) begin
         csr_prdata = CSR_DW'(method_ff);
      end
   end

   // classifier and count memory
   octab_binner #(.NUM_BINS(NUM_BINS)) u_binner (
      .clock   (clock),
      .load    (bin_load),
      .value   (value_ff),
      .method  (method_ff),
      .bin_res (bin_res)
   );

   assign upd_addr    = AW'(bin_res.bin) + AW'(pass2_ff);
   assign mem_rd_addr = (state_ff == ST_READ) ? upd_addr : emit_idx_ff;

   // saturating add of one or two half-units
   assign upd_sum     = {1'b0, mem_rd_data} + (CNT_W+1)'(bin_res.half ? 2'd1 : 2'd2);
   assign mem_wr_data = upd_sum[CNT_W] ? {CNT_W{1'b1}} : upd_sum[CNT_W-1:0];

   octab_count_ram #(.NUM_BINS(NUM_BINS)) u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd),
      .rd_clr  (mem_clr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr),
      .wr_addr (upd_addr),
      .wr_data (mem_wr_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            if (value_ff != '0) begin
               state_in = ST_READ;
            end else if (eos_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_MODIFY;
         ST_MODIFY: begin
            if (bin_res.half && !pass2_ff) begin
               state_in = ST_READ;
            end else if (eos_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD:   state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (rsp_xfer) begin
               state_in = (emit_idx_ff == LAST_IDX) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      bin_load   = 1'b0;
      mem_rd     = 1'b0;
      mem_clr    = 1'b0;
      mem_wr     = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_BIN:       bin_load   = 1'b1;
         ST_READ:      mem_rd     = 1'b1;
         ST_MODIFY:    mem_wr     = 1'b1;
         ST_EMIT_RD: begin
            mem_rd  = 1'b1;
            mem_clr = 1'b1;
         end
         ST_EMIT_WAIT: out_load   = 1'b1;
         ST_EMIT_OUT:  ;
         default:      ;
      endcase
   end

   // running total and modal bin over the emitted counts
   assign emit_cnt  = mem_rd_data[CNT_W-1:1];
   assign total_sum = {1'b0, total_ff} + {1'b0, emit_cnt};

   always_comb begin
      total_in    = total_sum[VAL_W] ? {VAL_W{1'b1}} : total_sum[VAL_W-1:0];
      best_cnt_in = best_cnt_ff;
      best_bin_in = best_bin_ff;
      if (emit_cnt > best_cnt_ff) begin
         best_cnt_in = emit_cnt;
         best_bin_in = IDX_W'(emit_idx_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass2_ff     <= 1'b0;
         emit_idx_ff  <= '0;
         total_ff     <= '0;
         best_cnt_ff  <= '0;
         best_bin_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_BIN) begin
            pass2_ff <= 1'b0;
         end else if (state_ff == ST_MODIFY && bin_res.half) begin
            pass2_ff <= 1'b1;
         end
         if (out_load) begin
            total_ff     <= total_in;
            best_cnt_ff  <= best_cnt_in;
            best_bin_ff  <= best_bin_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            out_valid_ff <= 1'b0;
            if (emit_idx_ff == LAST_IDX) begin
               emit_idx_ff <= '0;
               total_ff    <= '0;
               best_cnt_ff <= '0;
               best_bin_ff <= '0;
            end else begin
               emit_idx_ff <= emit_idx_ff + AW'(1);
            end
         end
      end
   end

   // input and output payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         value_ff <= req_tdata;
         eos_ff   <= req_tlast;
      end
      if (out_load) begin
         out_bin_ff   <= IDX_W'(emit_idx_ff);
         out_cnt_ff   <= emit_cnt;
         out_last_ff  <= (emit_idx_ff == LAST_IDX);
         out_total_ff <= (emit_idx_ff == LAST_IDX) ? total_in : '0;
         out_modal_ff <= (emit_idx_ff == LAST_IDX) ? best_bin_in : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0, out_modal_ff, out_total_ff, out_cnt_ff, out_bin_ff};

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[4:0] == IDX_W'(NUM_BINS - 1))
      else $error("last result is not the last bin");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[73:37] == '0)
      else $error("summary fields set on a non-final result");

   a_accept_bins: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_BIN)
      else $error("accepted item not classified");

endmodule
